>>> sv/pdfm_pkg.sv
// pdfm_pkg: shared types and constants of the pwm duty and frequency meter
// used by the controller, the datapath and the top level
package pdfm_pkg;

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 56;
  localparam int DUTY_W      = 7;
  localparam int OUT16_W     = 16;
  localparam int CLOCK_HZ_W  = 24;

  localparam logic [CLOCK_HZ_W-1:0] CLOCK_HZ_RESET  = 24'd8000000;
  localparam logic                  FILTER_ON_RESET = 1'b1;

  // register index taken from paddr[2]
  localparam logic REG_CLOCK_HZ  = 1'b0;
  localparam logic REG_FILTER_ON = 1'b1;

  typedef struct packed {
    logic tick;
    logic cap_rise;
    logic cap_fall;
    logic cap_end;
    logic prep;
    logic div_start;
    logic div_sel_freq;
    logic latch_duty;
    logic latch_freq;
    logic emit;
  } pdfm_cmd_t;

  typedef struct packed {
    logic start;
    logic rise;
    logic fall;
    logic in_range;
    logic div_done;
    logic out_busy;
  } pdfm_sts_t;

endpackage

>>> sv/pdfm_div.sv
// pdfm_div: restoring divider, one quotient bit per cycle
// no package dependency
module pdfm_div #(
  parameter int DW = 24,
  parameter int VW = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int CW = $clog2(DW + 1);

  logic          busy_r, busy_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [DW-1:0] quo_r, quo_nxt;
  logic [VW-1:0] rem_r, rem_nxt;
  logic [VW:0]   shifted;
  logic [VW:0]   diff;
  logic          ge;

  assign shifted = {rem_r, quo_r[DW-1]};
  assign diff    = shifted - {1'b0, divisor};
  assign ge      = shifted >= {1'b0, divisor};

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(DW);
      quo_nxt  = dividend;
      rem_nxt  = '0;
    end else if (busy_r) begin
      if (cnt_r != '0) begin
        cnt_nxt = cnt_r - 1'b1;
        quo_nxt = {quo_r[DW-2:0], ge};
        rem_nxt = ge ? diff[VW-1:0] : shifted[VW-1:0];
      end else begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  assign done     = busy_r && (cnt_r == '0);
  assign quotient = quo_r;

endmodule

>>> sv/pdfm_dp.sv
// pdfm_dp: tick counter, noise filter, edge captures, divider and result register
// depends on pdfm_pkg and pdfm_div
module pdfm_dp
  import pdfm_pkg::*;
#(
  parameter int COUNT_BITS     = 16,
  parameter int FILTER_SAMPLES = 4
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  pdfm_cmd_t              cmd,
  output pdfm_sts_t              sts,
  input  logic                   start_req,
  input  logic                   level,
  input  logic [CLOCK_HZ_W-1:0]  clock_hz,
  input  logic                   noise_filter_on,
  input  logic                   out_tready,
  output logic                   out_tvalid,
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam int DW = (COUNT_BITS + DUTY_W > CLOCK_HZ_W) ? COUNT_BITS + DUTY_W : CLOCK_HZ_W;

  logic [COUNT_BITS-1:0]     tick_r, tick_nxt;
  logic [FILTER_SAMPLES-1:0] hist_r, hist_nxt;
  logic                      filt_r, filt_nxt;
  logic [COUNT_BITS-1:0]     rise_stamp_r, rise_stamp_nxt;
  logic [COUNT_BITS-1:0]     fall_stamp_r, fall_stamp_nxt;
  logic [COUNT_BITS-1:0]     end_stamp_r, end_stamp_nxt;
  logic [COUNT_BITS-1:0]     high_r, high_nxt;
  logic [COUNT_BITS-1:0]     period_r, period_nxt;
  logic                      in_range_r, in_range_nxt;
  logic [DUTY_W-1:0]         duty_r, duty_nxt;
  logic [OUT16_W-1:0]        freq_r, freq_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0]    out_data_r, out_data_nxt;
  logic [DW-1:0]             high_ext;
  logic [DW-1:0]             dividend;
  logic [DW-1:0]             quotient;
  logic                      div_done;

  function automatic logic [OUT16_W-1:0] sat16(input logic [31:0] v);
    return (v > 32'd65535) ? 16'hFFFF : v[15:0];
  endfunction

  // sample filter and edge detect
  assign hist_nxt = FILTER_SAMPLES'({hist_r, level});

  always_comb begin
    filt_nxt = filt_r;
    if (!noise_filter_on) begin
      filt_nxt = level;
    end else if (&hist_nxt) begin
      filt_nxt = 1'b1;
    end else if (~|hist_nxt) begin
      filt_nxt = 1'b0;
    end
  end

  assign tick_nxt       = cmd.tick ? tick_r + 1'b1 : tick_r;
  assign rise_stamp_nxt = cmd.cap_rise ? tick_r : rise_stamp_r;
  assign fall_stamp_nxt = cmd.cap_fall ? tick_r : fall_stamp_r;
  assign end_stamp_nxt  = cmd.cap_end ? tick_r : end_stamp_r;

  assign high_nxt     = cmd.prep ? fall_stamp_r - rise_stamp_r : high_r;
  assign period_nxt   = cmd.prep ? end_stamp_r - rise_stamp_r : period_r;
  assign in_range_nxt = cmd.prep ? (rise_stamp_r < fall_stamp_r) && (fall_stamp_r < end_stamp_r)
                                 : in_range_r;

  // high * 100 as shifted sum
  assign high_ext = DW'(high_r);
  assign dividend = cmd.div_sel_freq ? DW'(clock_hz)
                                     : (high_ext << 6) + (high_ext << 5) + (high_ext << 2);

  pdfm_div #(
    .DW (DW),
    .VW (COUNT_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (period_r),
    .done     (div_done),
    .quotient (quotient)
  );

  assign duty_nxt = cmd.latch_duty ? quotient[DUTY_W-1:0] : duty_r;
  assign freq_nxt = cmd.latch_freq ? ((quotient > DW'(32'd65535)) ? 16'hFFFF : quotient[15:0])
                                   : freq_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
      if (in_range_r) begin
        out_data_nxt = {sat16(32'(period_r)), sat16(32'(high_r)), freq_r, duty_r, 1'b1};
      end else begin
        out_data_nxt = '0;
      end
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r       <= '0;
      hist_r       <= '0;
      filt_r       <= 1'b0;
      rise_stamp_r <= '0;
      fall_stamp_r <= '0;
      in_range_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      tick_r       <= tick_nxt;
      if (cmd.tick) begin
        hist_r <= hist_nxt;
        filt_r <= filt_nxt;
      end
      rise_stamp_r <= rise_stamp_nxt;
      fall_stamp_r <= fall_stamp_nxt;
      in_range_r   <= in_range_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    end_stamp_r <= end_stamp_nxt;
    high_r      <= high_nxt;
    period_r    <= period_nxt;
    duty_r      <= duty_nxt;
    freq_r      <= freq_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign sts.start    = start_req;
  assign sts.rise     = ~filt_r & filt_nxt;
  assign sts.fall     = filt_r & ~filt_nxt;
  assign sts.in_range = in_range_r;
  assign sts.div_done = div_done;
  assign sts.out_busy = out_valid_r & ~out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

>>> sv/pdfm_ctrl.sv
// pdfm_ctrl: measurement phase and division sequencing state machine
// depends on pdfm_pkg
module pdfm_ctrl
  import pdfm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  pdfm_sts_t sts,
  output pdfm_cmd_t cmd
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_RISE1 = 3'd1;
  localparam logic [2:0] ST_FALL  = 3'd2;
  localparam logic [2:0] ST_RISE2 = 3'd3;
  localparam logic [2:0] ST_PREP  = 3'd4;
  localparam logic [2:0] ST_DLOAD = 3'd5;
  localparam logic [2:0] ST_DUTY  = 3'd6;
  localparam logic [2:0] ST_FREQ  = 3'd7;
  localparam logic [2:0] ST_EMIT  = ST_IDLE;

  logic [2:0] state_r, state_nxt;
  logic       emit_r, emit_nxt;
  logic       in_fire;

  assign in_tready = !emit_r && (state_r == ST_IDLE || state_r == ST_RISE1 ||
                                 state_r == ST_FALL || state_r == ST_RISE2);
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    emit_nxt  = emit_r;
    cmd       = '0;
    cmd.tick  = in_fire;
    if (emit_r) begin
      // result pending in idle: hand it to the output register
      if (!sts.out_busy) begin
        cmd.emit = 1'b1;
        emit_nxt = 1'b0;
      end
    end else begin
      unique case (state_r) inside
        ST_IDLE, ST_RISE1, ST_FALL, ST_RISE2: begin
          if (in_fire) begin
            if (sts.start) begin
              state_nxt = ST_RISE1;
            end else if (state_r == ST_RISE1 && sts.rise) begin
              cmd.cap_rise = 1'b1;
              state_nxt    = ST_FALL;
            end else if (state_r == ST_FALL && sts.fall) begin
              cmd.cap_fall = 1'b1;
              state_nxt    = ST_RISE2;
            end else if (state_r == ST_RISE2 && sts.rise) begin
              cmd.cap_end = 1'b1;
              state_nxt   = ST_PREP;
            end
          end
        end
        ST_PREP: begin
          cmd.prep  = 1'b1;
          state_nxt = ST_DLOAD;
        end
        ST_DLOAD: begin
          if (sts.in_range) begin
            cmd.div_start = 1'b1;
            state_nxt     = ST_DUTY;
          end else begin
            state_nxt = ST_EMIT;
            emit_nxt  = 1'b1;
          end
        end
        ST_DUTY: begin
          if (sts.div_done) begin
            cmd.latch_duty   = 1'b1;
            cmd.div_start    = 1'b1;
            cmd.div_sel_freq = 1'b1;
            state_nxt        = ST_FREQ;
          end
        end
        ST_FREQ: begin
          if (sts.div_done) begin
            cmd.latch_freq = 1'b1;
            state_nxt      = ST_EMIT;
            emit_nxt       = 1'b1;
          end
        end
        default: begin
          state_nxt = ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      emit_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      emit_r  <= emit_nxt;
    end
  end

`ifndef SYNTHESIS
  a_prep_then_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PREP && !emit_r) |=> (state_r == ST_DLOAD))
    else $error("prep not followed by divider load");

  a_emit_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !sts.out_busy)
    else $error("result written over a held result");

  a_end_to_prep: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cap_end |=> (state_r == ST_PREP && !in_tready))
    else $error("third capture not followed by prep");

  a_div_only_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> sts.in_range)
    else $error("division started on out of range captures");
`endif

endmodule

>>> sv/pwm_duty_frequency_meter_top.sv
// pwm_duty_frequency_meter_top: register port, controller and datapath of the meter
// depends on pdfm_pkg, pdfm_ctrl, pdfm_dp
//
// usage
//   input stream: one request per clock tick of the measured signal, carrying
//   start_req and the sampled level; every accepted request advances the tick
//   counter by one. after a start, the first rising, the next falling and the
//   next rising edge of the (optionally filtered) level are captured.
//   output stream: one result per completed measurement with in_range, duty,
//   frequency, high time and period; out of range captures give zeros.
//   throughput: one input request per cycle while capturing. the request that
//   completes a measurement is followed by in_tready low while the captures are
//   prepared and, when in range, the shared one-bit-per-cycle divider, DW =
//   max(COUNT_BITS+7, 24) bits wide, runs twice, for duty and then frequency.
//   the result appears on out_tvalid as in_tready returns high.
//   stall: a held result does not block input; a second result waits in the
//   controller, with in_tready low, until the first has been taken.
//   reset: counter, filter, rise and fall captures cleared, measurement idle,
//   registers at clock_hz 8000000, noise_filter_on 1; map: 0x0 clock_hz, 0x4 filter
module pwm_duty_frequency_meter_top
  import pdfm_pkg::*;
#(
  parameter int COUNT_BITS     = 16,
  parameter int FILTER_SAMPLES = 4
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,    // [0] start_req, [1] level
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,   // [0] in_range, [7:1] duty_percent,
                                              // [23:8] frequency_hz, [39:24] high_ticks,
                                              // [55:40] period_ticks
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [2:0]             cfg_paddr,
  input  logic [31:0]            cfg_pwdata,
  output logic [31:0]            cfg_prdata,
  output logic                   cfg_pready
);

  logic [CLOCK_HZ_W-1:0] clock_hz_r, clock_hz_nxt;
  logic                  filter_on_r, filter_on_nxt;
  logic                  cfg_wr;
  pdfm_cmd_t             cmd;
  pdfm_sts_t             sts;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    clock_hz_nxt  = clock_hz_r;
    filter_on_nxt = filter_on_r;
    if (cfg_wr) begin
      unique case (cfg_paddr[2])
        REG_CLOCK_HZ:  clock_hz_nxt  = cfg_pwdata[CLOCK_HZ_W-1:0];
        REG_FILTER_ON: filter_on_nxt = cfg_pwdata[0];
        default:       clock_hz_nxt  = clock_hz_r;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      REG_CLOCK_HZ:  cfg_prdata = 32'(clock_hz_r);
      REG_FILTER_ON: cfg_prdata = 32'(filter_on_r);
      default:       cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_hz_r  <= CLOCK_HZ_RESET;
      filter_on_r <= FILTER_ON_RESET;
    end else begin
      clock_hz_r  <= clock_hz_nxt;
      filter_on_r <= filter_on_nxt;
    end
  end

  pdfm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  pdfm_dp #(
    .COUNT_BITS     (COUNT_BITS),
    .FILTER_SAMPLES (FILTER_SAMPLES)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .start_req       (in_tdata[0]),
    .level           (in_tdata[1]),
    .clock_hz        (clock_hz_r),
    .noise_filter_on (filter_on_r),
    .out_tready      (out_tready),
    .out_tvalid      (out_tvalid),
    .out_tdata       (out_tdata)
  );

endmodule
